[rtl/assert_macros.svh]
// Assertion macros used by the checker file yrs_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that is checked during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/yrs_pkg.sv]
// Constants and helper functions for the YUV to RGB converter with SAD.
// No dependencies; used by the top level and its checker.
package yrs_pkg;

	localparam int ACC_WIDTH = 40;
	localparam int DIFF_W    = 40;
	localparam int PIX_W     = 8;
	localparam int FRAC_BITS = 16;
	// signed Q.16 channel sum, wide enough for every byte pattern
	localparam int SUM_W     = 28;
	localparam int COEF_W    = 18;
	localparam int SADD_W    = PIX_W + 2;

	localparam int IN_DATA_W  = 6 * PIX_W;
	localparam int OUT_DATA_W = 3 * PIX_W + DIFF_W;

	localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

	// full-range matrix, Q.16
	localparam logic signed [COEF_W-1:0] K_R_CB = 18'sd199;
	localparam logic signed [COEF_W-1:0] K_R_CR = 18'sd91715;
	localparam logic signed [COEF_W-1:0] K_G_CB = 18'sd22559;
	localparam logic signed [COEF_W-1:0] K_G_CR = 18'sd47003;
	localparam logic signed [COEF_W-1:0] K_B_CB = 18'sd116158;
	localparam logic signed [COEF_W-1:0] K_B_CR = 18'sd402;

	typedef logic [PIX_W-1:0] pix_t;

	// negative -> 0, drop fraction, saturate at 255
	function automatic pix_t clamp_q16(input logic signed [SUM_W-1:0] v);
		pix_t res;
		if (v[SUM_W-1]) begin
			res = '0;
		end else if (|v[SUM_W-2:FRAC_BITS+PIX_W]) begin
			res = '1;
		end else begin
			res = v[FRAC_BITS+PIX_W-1:FRAC_BITS];
		end
		return res;
	endfunction

	function automatic pix_t abs_diff(input pix_t a, input pix_t b);
		pix_t res;
		if (a > b) begin
			res = a - b;
		end else begin
			res = b - a;
		end
		return res;
	endfunction

endpackage

[rtl/yuv_to_rgb_with_sad.sv]
// Pixel converter: NV21 YCrCb or RGB888 in, clamped RGB888 out, with a running
// sum of absolute differences against a golden pixel. Depends on yrs_pkg.
//
// Usage:
//   Input stream s_*: one pixel per transfer. s_tdata carries the three samples
//   and the golden RGB bytes; s_tuser is frame_start, which clears the SAD
//   accumulator before this pixel's difference is added.
//   Output stream m_*: one result per input pixel, in order. m_tdata carries
//   the converted RGB bytes and the saturating SAD total after this pixel.
//   cfg_wr_en/cfg_wr_data write pixel_format (0 NV21, 1 RGB888); write it only
//   while no pixel is in flight.
// Timing:
//   From input transfer to m_tvalid there is an input register, then the
//   matrix, clamp, difference and accumulate logic into the result register.
//   One pixel per cycle sustained while m_tready is high; the accumulator add
//   closes in the result stage.
// Reset (arst_n low) empties both stages, clears the accumulator and sets
// pixel_format to NV21. When m_tready is low the result holds and the input
// register, if empty, still takes one more pixel before s_tready drops.
module yuv_to_rgb_with_sad (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sample_first, sample_second, sample_third, golden_red, golden_green, golden_blue
	input  logic [yrs_pkg::IN_DATA_W-1:0]    s_tdata,
	// frame_start
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_red, out_green, out_blue, diff_total
	output logic [yrs_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int PW = yrs_pkg::PIX_W;
	localparam int SW = yrs_pkg::SUM_W;
	localparam int AW = yrs_pkg::ACC_WIDTH;

	logic fmt_q;

	logic                 valid_s1;
	yrs_pkg::pix_t        samp0_s1, samp1_s1, samp2_s1;
	yrs_pkg::pix_t        gold_r_s1, gold_g_s1, gold_b_s1;
	logic                 start_s1;

	logic                 valid_s2;
	yrs_pkg::pix_t        red_s2, green_s2, blue_s2;
	logic [AW-1:0]        acc_q;

	logic advance, load_s1;

	logic signed [PW-1:0] cr, cb;
	logic signed [SW-1:0] yq;
	logic signed [SW-1:0] p_r_cb, p_r_cr, p_g_cb, p_g_cr, p_b_cb, p_b_cr;
	logic signed [SW-1:0] sum_r, sum_g, sum_b;
	yrs_pkg::pix_t        pix_r, pix_g, pix_b;
	logic [yrs_pkg::SADD_W-1:0] sad;
	logic [AW-1:0]        acc_base, acc_next;
	logic [AW:0]          acc_sum;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			samp0_s1  <= s_tdata[0*PW +: PW];
			samp1_s1  <= s_tdata[1*PW +: PW];
			samp2_s1  <= s_tdata[2*PW +: PW];
			gold_r_s1 <= s_tdata[3*PW +: PW];
			gold_g_s1 <= s_tdata[4*PW +: PW];
			gold_b_s1 <= s_tdata[5*PW +: PW];
			start_s1  <= s_tuser;
		end
	end

	// chroma minus 128 is the byte with its top bit flipped, read as signed
	assign cr = $signed({~samp1_s1[PW-1], samp1_s1[PW-2:0]});
	assign cb = $signed({~samp2_s1[PW-1], samp2_s1[PW-2:0]});
	assign yq = $signed({{(SW-PW-yrs_pkg::FRAC_BITS){1'b0}}, samp0_s1,
		{yrs_pkg::FRAC_BITS{1'b0}}});

	assign p_r_cb = SW'(yrs_pkg::K_R_CB) * SW'(cb);
	assign p_r_cr = SW'(yrs_pkg::K_R_CR) * SW'(cr);
	assign p_g_cb = SW'(yrs_pkg::K_G_CB) * SW'(cb);
	assign p_g_cr = SW'(yrs_pkg::K_G_CR) * SW'(cr);
	assign p_b_cb = SW'(yrs_pkg::K_B_CB) * SW'(cb);
	assign p_b_cr = SW'(yrs_pkg::K_B_CR) * SW'(cr);

	assign sum_r = yq + p_r_cb + p_r_cr;
	assign sum_g = yq - p_g_cb - p_g_cr;
	assign sum_b = yq + p_b_cb - p_b_cr;

	always_comb begin
		if (fmt_q) begin
			pix_r = samp0_s1;
			pix_g = samp1_s1;
			pix_b = samp2_s1;
		end else begin
			pix_r = yrs_pkg::clamp_q16(sum_r);
			pix_g = yrs_pkg::clamp_q16(sum_g);
			pix_b = yrs_pkg::clamp_q16(sum_b);
		end
	end

	assign sad = yrs_pkg::SADD_W'(yrs_pkg::abs_diff(pix_r, gold_r_s1))
		+ yrs_pkg::SADD_W'(yrs_pkg::abs_diff(pix_g, gold_g_s1))
		+ yrs_pkg::SADD_W'(yrs_pkg::abs_diff(pix_b, gold_b_s1));

	// carry out of the add means saturation
	assign acc_base = start_s1 ? '0 : acc_q;
	assign acc_sum  = {1'b0, acc_base} + (AW+1)'(sad);
	assign acc_next = acc_sum[AW] ? yrs_pkg::ACC_MAX : acc_sum[AW-1:0];

	// result register; acc_q always matches the result on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			red_s2   <= pix_r;
			green_s2 <= pix_g;
			blue_s2  <= pix_b;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {yrs_pkg::DIFF_W'(acc_q), blue_s2, green_s2, red_s2};

endmodule

[rtl/yrs_checker.sv]
// Port-level checks for yuv_to_rgb_with_sad, attached by bind.
// Depends on yrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module yrs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [yrs_pkg::OUT_DATA_W-1:0] m_tdata
);

	`ASSERT_CLKD(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`ASSERT_CLK(a_reset_empty, clk, !arst_n |-> !m_tvalid, "result valid during reset")
	`ASSERT_CLKD(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready, "input blocked with empty output")
	`ASSERT_CLKD(a_latency, clk, arst_n, s_tvalid && s_tready |-> ##2 m_tvalid, "accepted pixel missing at output")

endmodule

bind yuv_to_rgb_with_sad yrs_checker u_yrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/tb_yuv_to_rgb_with_sad.sv]
// Testbench for yuv_to_rgb_with_sad: NV21/RGB888 pixel conversion and SAD accumulation
// with an in-order result tracker, random back-pressure and format changes.
// Depends on yrs_pkg and the yuv_to_rgb_with_sad RTL.
module tb_yuv_to_rgb_with_sad;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int MAX_REPORTS    = 10;
	localparam int HOLD_AT_RESULT = 700;
	localparam int HOLD_CYCLES    = 64;

	localparam bit FMT_NV21   = 1'b0;
	localparam bit FMT_RGB888 = 1'b1;

	// conversion matrix, signed Q.16
	localparam int MUL_R_CB = 199;
	localparam int MUL_R_CR = 91715;
	localparam int MUL_G_CB = 22559;
	localparam int MUL_G_CR = 47003;
	localparam int MUL_B_CB = 116158;
	localparam int MUL_B_CR = 402;

	typedef yrs_pkg::pix_t pix_t;

	typedef struct packed {
		logic frame_start;
		pix_t gold_b;
		pix_t gold_g;
		pix_t gold_r;
		pix_t third;
		pix_t second;
		pix_t first;
	} pixel_in_t;

	// same layout as m_tdata, red in the low byte
	typedef struct packed {
		logic [yrs_pkg::DIFF_W-1:0] total;
		pix_t blue;
		pix_t green;
		pix_t red;
	} rgb_sad_t;

	class sad_tracker;
		bit              rgb_mode;
		longint unsigned sad_acc;
		longint unsigned sad_limit;
		rgb_sad_t        expected_pixels[$];
		int              mismatch_count;

		function new();
			rgb_mode       = FMT_NV21;
			sad_acc        = 0;
			sad_limit      = (64'd1 << yrs_pkg::ACC_WIDTH) - 64'd1;
			mismatch_count = 0;
		endfunction

		function void set_format(input bit fmt);
			rgb_mode = fmt;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function pix_t q16_to_byte(input int v);
			int whole;
			if (v < 0) begin
				return 8'd0;
			end
			whole = v >>> 16;
			if (whole > 255) begin
				return 8'd255;
			end
			return pix_t'(whole);
		endfunction

		function int byte_gap(input pix_t a, input pix_t b);
			return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
		endfunction

		function void convert(input pixel_in_t px, input bit fmt,
				output pix_t r, output pix_t g, output pix_t b);
			int luma;
			int cr;
			int cb;
			if (fmt == FMT_RGB888) begin
				r = px.first;
				g = px.second;
				b = px.third;
			end else begin
				luma = int'(px.first) * 65536;
				cr   = int'(px.second) - 128;
				cb   = int'(px.third) - 128;
				r = q16_to_byte(luma + MUL_R_CB * cb + MUL_R_CR * cr);
				g = q16_to_byte(luma - MUL_G_CB * cb - MUL_G_CR * cr);
				b = q16_to_byte(luma + MUL_B_CB * cb - MUL_B_CR * cr);
			end
		endfunction

		function void note_pixel(input pixel_in_t px);
			pix_t            r;
			pix_t            g;
			pix_t            b;
			longint unsigned d;
			rgb_sad_t        e;
			convert(px, rgb_mode, r, g, b);
			if (px.frame_start) begin
				sad_acc = 0;
			end
			d = longint'(byte_gap(r, px.gold_r) + byte_gap(g, px.gold_g)
				+ byte_gap(b, px.gold_b));
			if (sad_acc > sad_limit - d) begin
				sad_acc = sad_limit;
			end else begin
				sad_acc = sad_acc + d;
			end
			e.red   = r;
			e.green = g;
			e.blue  = b;
			e.total = sad_acc[yrs_pkg::DIFF_W-1:0];
			expected_pixels.push_back(e);
		endfunction

		function bit log_mismatch();
			mismatch_count++;
			return mismatch_count <= MAX_REPORTS;
		endfunction

		function void check_result(input rgb_sad_t got);
			rgb_sad_t want;
			if (expected_pixels.size() == 0) begin
				if (log_mismatch()) begin
					$display("unexpected result r=%0d g=%0d b=%0d sad=%0d",
						got.red, got.green, got.blue, got.total);
				end
				return;
			end
			want = expected_pixels.pop_front();
			if (got !== want) begin
				if (log_mismatch()) begin
					$display("mismatch: expected r=%0d g=%0d b=%0d sad=%0d, got r=%0d g=%0d b=%0d sad=%0d",
						want.red, want.green, want.blue, want.total,
						got.red, got.green, got.blue, got.total);
				end
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic                            cfg_wr_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [yrs_pkg::IN_DATA_W-1:0]   s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [yrs_pkg::OUT_DATA_W-1:0]  m_tdata;

	sad_tracker tracker = new();
	int         send_idle_pct = 20;
	int         recv_idle_pct = 56;
	int         results_seen = 0;
	int         hold_left = 0;
	int         cycle_count = 0;

	yuv_to_rgb_with_sad dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb_yuv_to_rgb_with_sad NOT OK");
				$finish;
			end
		end
	end

	// result side: check each transfer, then pick next tready
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				tracker.check_result(rgb_sad_t'(m_tdata));
				results_seen++;
				// long hold-off so the pipeline fills and input stalls
				if (results_seen == HOLD_AT_RESULT) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	function automatic pixel_in_t make_px(input pix_t f, input pix_t s, input pix_t t,
			input pix_t gr, input pix_t gg, input pix_t gb, input logic fs);
		pixel_in_t px;
		px.first       = f;
		px.second      = s;
		px.third       = t;
		px.gold_r      = gr;
		px.gold_g      = gg;
		px.gold_b      = gb;
		px.frame_start = fs;
		return px;
	endfunction

	task automatic send_pixel(input pixel_in_t px);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {px.gold_b, px.gold_g, px.gold_r, px.third, px.second, px.first};
		s_tuser  <= px.frame_start;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		tracker.note_pixel(px);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end
		// two-stage pipeline, allow a little slack
		repeat (4) @(posedge clk);
	endtask

	task automatic write_format(input bit fmt);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= fmt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_format(fmt);
	endtask

	function automatic pix_t rand_byte();
		if ($urandom_range(9, 0) == 0) begin
			return ($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00;
		end
		return 8'($urandom);
	endfunction

	function automatic pix_t near_byte(input pix_t v);
		int n;
		n = int'(v) + $urandom_range(6, 0) - 3;
		if (n < 0) begin
			n = 0;
		end else if (n > 255) begin
			n = 255;
		end
		return pix_t'(n);
	endfunction

	// frames of random length with random content; golden is mostly close to
	// the converted pixel, the rest arbitrary, plus stray frame starts
	task automatic run_random(input bit fmt, input int count);
		int        sent;
		int        frame_left;
		pixel_in_t px;
		pix_t      r;
		pix_t      g;
		pix_t      b;
		write_format(fmt);
		sent       = 0;
		frame_left = 0;
		while (sent < count) begin
			px.first  = rand_byte();
			px.second = rand_byte();
			px.third  = rand_byte();
			if ($urandom_range(9, 0) < 6) begin
				tracker.convert(px, fmt, r, g, b);
				px.gold_r = near_byte(r);
				px.gold_g = near_byte(g);
				px.gold_b = near_byte(b);
			end else begin
				px.gold_r = rand_byte();
				px.gold_g = rand_byte();
				px.gold_b = rand_byte();
			end
			if (frame_left == 0) begin
				px.frame_start = 1'b1;
				frame_left = $urandom_range(40, 1);
			end else begin
				px.frame_start = ($urandom_range(19, 0) == 0);
			end
			frame_left--;
			send_pixel(px);
			sent++;
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct <= 20;
		recv_idle_pct <= 56;

		write_format(FMT_NV21);
		send_pixel(make_px(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1));
		send_pixel(make_px(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
		send_pixel(make_px(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0));
		send_pixel(make_px(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   1'b0));
		send_pixel(make_px(8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 1'b0));
		send_pixel(make_px(8'd0,   8'd128, 8'd128, 8'd255, 8'd255, 8'd255, 1'b0));
		send_pixel(make_px(8'd255, 8'd128, 8'd128, 8'd0,   8'd0,   8'd0,   1'b0));
		send_pixel(make_px(8'd16,  8'd240, 8'd16,  8'd200, 8'd60,  8'd10,  1'b1));
		send_pixel(make_px(8'd235, 8'd16,  8'd240, 8'd20,  8'd250, 8'd255, 1'b0));
		send_pixel(make_px(8'd1,   8'd127, 8'd129, 8'd1,   8'd1,   8'd1,   1'b0));
		send_pixel(make_px(8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1));
		send_pixel(make_px(8'h55,  8'hAA,  8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0));

		write_format(FMT_RGB888);
		send_pixel(make_px(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b1));
		send_pixel(make_px(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0));
		send_pixel(make_px(8'hAA,  8'h55,  8'hF0,  8'h55,  8'hAA,  8'h0F,  1'b0));
		send_pixel(make_px(8'h5A,  8'hA5,  8'h3C,  8'h5A,  8'hA5,  8'h3C,  1'b0));
		send_pixel(make_px(8'h01,  8'h80,  8'hFE,  8'hFE,  8'h7F,  8'h01,  1'b1));
		send_pixel(make_px(8'h55,  8'hAA,  8'h0F,  8'hAA,  8'h55,  8'hF0,  1'b0));

		run_random(FMT_NV21, 150);
		run_random(FMT_RGB888, 150);

		// roles swapped
		send_idle_pct <= 56;
		recv_idle_pct <= 20;
		run_random(FMT_RGB888, 150);
		run_random(FMT_NV21, 150);

		// full rate both sides; the receiver hold-off lands here
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		run_random(FMT_NV21, 150);
		run_random(FMT_RGB888, 127);

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
			$display("tb_yuv_to_rgb_with_sad OK");
		end else begin
			$display("tb_yuv_to_rgb_with_sad NOT OK");
		end
		$finish;
	end

endmodule
